### rtl/core/ccq_pkg.sv
// Shared types, constants and the fixed task decompose table of the
// coalescing command queue. No dependencies.
package ccq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 20;
  localparam int unsigned TASK_IDS        = 20;
  localparam int unsigned ACTION_COUNT    = 12;
  localparam int unsigned ROW_MAX         = 6;
  localparam int unsigned LIST_IW         = $clog2(ACTION_COUNT);
  localparam int unsigned LIST_CW         = $clog2(ACTION_COUNT + 1);

  typedef logic [4:0] task_id_t;
  typedef logic [3:0] action_t;
  typedef logic [2:0] row_idx_t;

  localparam task_id_t TASK_ALL = 5'd19;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_ROW,
    ST_EMIT
  } ccq_state_t;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_EXEC = 1'b1
  } req_type_t;

  typedef struct packed {
    logic push;
    logic start;
    logic row_step;
    logic next_task;
    logic emit_step;
    logic finish;
  } ccq_cmd_t;

  typedef struct packed {
    logic req_exec;
    logic q_empty;
    logic row_end;
    logic task_last;
    logic list_empty;
    logic emit_last;
  } ccq_stat_t;

  function automatic row_idx_t row_len(input task_id_t t);
    row_idx_t len;
    case (t)
      5'd0:    len = 3'd1;
      5'd1:    len = 3'd1;
      5'd4:    len = 3'd3;
      5'd5:    len = 3'd1;
      5'd6:    len = 3'd2;
      5'd7:    len = 3'd3;
      5'd8:    len = 3'd2;
      5'd9:    len = 3'd1;
      5'd10:   len = 3'd2;
      5'd11:   len = 3'd1;
      5'd13:   len = 3'd1;
      5'd14:   len = 3'd6;
      5'd15:   len = 3'd1;
      5'd16:   len = 3'd2;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // Row entry k sits in nibble k.
  function automatic logic [23:0] row_bits(input task_id_t t);
    logic [23:0] b;
    case (t)
      5'd0:    b = 24'h000009;
      5'd1:    b = 24'h000008;
      5'd4:    b = 24'h000890;
      5'd5:    b = 24'h000002;
      5'd6:    b = 24'h000061;
      5'd7:    b = 24'h000804;
      5'd8:    b = 24'h000060;
      5'd9:    b = 24'h000007;
      5'd10:   b = 24'h000063;
      5'd11:   b = 24'h000005;
      5'd13:   b = 24'h000006;
      5'd14:   b = 24'h530412;
      5'd15:   b = 24'h00000a;
      5'd16:   b = 24'h0000ab;
      default: b = 24'h000000;
    endcase
    return b;
  endfunction

  function automatic action_t row_code(input task_id_t t, input row_idx_t k);
    logic [23:0] b;
    b = row_bits(t);
    return b[{k, 2'b00} +: 4];
  endfunction

endpackage

### rtl/core/ccq_ctrl.sv
// Sequencing controller of the coalescing command queue.
// Depends on ccq_pkg for the state, command and status types.
module ccq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ccq_pkg::ccq_stat_t st,
  output ccq_pkg::ccq_cmd_t  cmd
);
  import ccq_pkg::*;

  ccq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && st.req_exec && !st.q_empty) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_ROW;
      end
      ST_ROW: begin
        if (st.row_end) begin
          if (!st.task_last) begin
            state_nxt = ST_FETCH;
          end else if (st.list_empty) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_ready && st.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.push  = in_valid && !st.req_exec;
        cmd.start = in_valid && st.req_exec && !st.q_empty;
      end
      ST_FETCH: begin
      end
      ST_ROW: begin
        cmd.row_step  = !st.row_end;
        cmd.next_task = st.row_end && !st.task_last;
        cmd.finish    = st.row_end && st.task_last && st.list_empty;
      end
      ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.emit_step = out_ready;
        cmd.finish    = out_ready && st.emit_last;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/ccq_dp.sv
// Datapath of the coalescing command queue: task store, dedup bitmap,
// row walker, action list and output select. Depends on ccq_pkg.
module ccq_dp #(
  parameter int unsigned QUEUE_DEPTH = ccq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_req_type,
  input  ccq_pkg::task_id_t        in_task_id,
  output ccq_pkg::action_t         out_action_code,
  output logic                     out_last_action,
  input  ccq_pkg::ccq_cmd_t        cmd,
  output ccq_pkg::ccq_stat_t       st
);
  import ccq_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH);
  localparam int unsigned NQ = TASK_IDS - 1;

  task_id_t                mem [QUEUE_DEPTH];
  task_id_t                rd_data_r;
  logic [CW-1:0]           count_r;
  logic                    all_r;
  logic [NQ-1:0]           queued_r;
  logic [CW-1:0]           idx_r;
  row_idx_t                k_r;
  logic [ACTION_COUNT-1:0] seen_r;
  action_t                 list_r [ACTION_COUNT];
  logic [LIST_CW-1:0]      n_r;
  logic [LIST_IW-1:0]      e_r;

  task_id_t cur_task;
  action_t  cur_code;
  logic     push_ok;
  logic     new_code;

  assign cur_task = all_r ? task_id_t'(idx_r) : rd_data_r;
  assign cur_code = row_code(cur_task, k_r);
  assign new_code = !seen_r[cur_code];

  assign push_ok = (in_task_id < TASK_ALL) && !(all_r && count_r != '0)
                   && !queued_r[in_task_id]
                   && ({1'b0, count_r} < (CW+1)'(QUEUE_DEPTH - 1));

  always_ff @(posedge clk) begin
    rd_data_r <= mem[idx_r];
    if (cmd.push && push_ok) begin
      mem[count_r] <= in_task_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      all_r    <= 1'b0;
      queued_r <= '0;
      seen_r   <= '0;
      n_r      <= '0;
      idx_r    <= '0;
      k_r      <= '0;
      e_r      <= '0;
    end else begin
      if (cmd.push) begin
        if (in_task_id == TASK_ALL) begin
          all_r    <= 1'b1;
          count_r  <= CW'(1);
          queued_r <= '0;
        end else if (push_ok) begin
          count_r            <= count_r + 1'b1;
          queued_r[in_task_id] <= 1'b1;
        end
      end
      if (cmd.start) begin
        seen_r <= '0;
        n_r    <= '0;
        idx_r  <= '0;
        k_r    <= '0;
        e_r    <= '0;
      end
      if (cmd.row_step) begin
        k_r <= k_r + 1'b1;
        if (new_code) begin
          seen_r[cur_code] <= 1'b1;
          n_r              <= n_r + 1'b1;
        end
      end
      if (cmd.next_task) begin
        idx_r <= idx_r + 1'b1;
        k_r   <= '0;
      end
      if (cmd.emit_step) begin
        e_r <= e_r + 1'b1;
      end
      if (cmd.finish) begin
        count_r  <= '0;
        all_r    <= 1'b0;
        queued_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_step && new_code) begin
      list_r[n_r[LIST_IW-1:0]] <= cur_code;
    end
  end

  assign st.req_exec   = (in_req_type == REQ_EXEC);
  assign st.q_empty    = (count_r == '0);
  assign st.row_end    = (k_r == row_len(cur_task));
  assign st.task_last  = all_r ? (idx_r == CW'(TASK_ALL - 1)) : (idx_r == count_r - 1'b1);
  assign st.list_empty = (n_r == '0);
  assign st.emit_last  = (LIST_CW'(e_r) + 1'b1 == n_r);

  assign out_action_code = list_r[e_r];
  assign out_last_action = st.emit_last;

endmodule

### rtl/core/coalescing_command_queue_unit.sv
// Top level of the coalescing command queue: controller plus datapath.
// Depends on ccq_pkg, ccq_ctrl and ccq_dp.
//
// Input channel (in_valid/in_ready): in_req_type 0 pushes in_task_id into
// the queue (repeats, ids above 19 and pushes behind a queued "all" are
// dropped; id 19 replaces the queue with "all"); 1 executes the queue.
// in_ready is high whenever no execute run is busy.
// An execute run walks the queued tasks (or tasks 0..18 for "all") through
// the decompose table: a store read and row setup for each task, then a
// walk over its row entries; then one transfer per distinct action code on
// the output channel (out_valid/out_ready), the last one flagged by
// out_last_action. An empty queue gives no transfer; a run that finds no
// action gives none either and still empties the queue.
// Output data sits in the action list registers; while out_ready is low
// the run holds and no new input is taken until the last transfer.
// Synchronous reset empties the queue and returns to idle.
module coalescing_command_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = ccq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  input  ccq_pkg::task_id_t in_task_id,
  output logic              out_valid,
  input  logic              out_ready,
  output ccq_pkg::action_t  out_action_code,
  output logic              out_last_action
);
  import ccq_pkg::*;

  ccq_cmd_t  cmd;
  ccq_stat_t st;

  ccq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  ccq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_req_type     (in_req_type),
    .in_task_id      (in_task_id),
    .out_action_code (out_action_code),
    .out_last_action (out_last_action),
    .cmd             (cmd),
    .st              (st)
  );

endmodule

### dv/tb_coalescing_command_queue_unit.sv
// Testbench for coalescing_command_queue_unit: random push/execute traffic checked
// against an action-list predictor, with random input gaps and random output back-pressure.
// Depends on ccq_pkg and the coalescing_command_queue_unit RTL.
module tb_coalescing_command_queue_unit;
  import ccq_pkg::*;

  localparam int unsigned QDEPTH      = QUEUE_DEPTH_DEF;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT  = 200;
  localparam int unsigned ITEM_GOAL   = 270;

  typedef struct packed {
    action_t code;
    logic    last;
  } action_entry_t;

  class ccq_action_model;
    task_id_t      queued[QDEPTH];
    int unsigned   depth_used;
    logic [ACTION_COUNT-1:0] seen;
    action_t       row_code_tbl[TASK_IDS][ROW_MAX];
    int unsigned   row_len_tbl[TASK_IDS];
    action_t       run_list[$];
    action_entry_t pending_actions[$];
    int unsigned   errors;

    function new();
      for (int t = 0; t < TASK_IDS; t++) begin
        row_len_tbl[t] = 0;
        for (int k = 0; k < ROW_MAX; k++) row_code_tbl[t][k] = '0;
      end
      add_row(0, 1, 9);
      add_row(1, 1, 8);
      add_row(4, 3, 0, 9, 8);
      add_row(5, 1, 2);
      add_row(6, 2, 1, 6);
      add_row(7, 3, 4, 0, 8);
      add_row(8, 2, 0, 6);
      add_row(9, 1, 7);
      add_row(10, 2, 3, 6);
      add_row(11, 1, 5);
      add_row(13, 1, 6);
      add_row(14, 6, 2, 1, 4, 0, 3, 5);
      add_row(15, 1, 10);
      add_row(16, 2, 11, 10);
      depth_used = 0;
      seen = '0;
      errors = 0;
    endfunction

    function void add_row(int t, int n, int c0, int c1 = 0, int c2 = 0, int c3 = 0,
                          int c4 = 0, int c5 = 0);
      row_len_tbl[t] = n;
      row_code_tbl[t][0] = action_t'(c0);
      row_code_tbl[t][1] = action_t'(c1);
      row_code_tbl[t][2] = action_t'(c2);
      row_code_tbl[t][3] = action_t'(c3);
      row_code_tbl[t][4] = action_t'(c4);
      row_code_tbl[t][5] = action_t'(c5);
    endfunction

    function void walk_row(task_id_t t);
      action_t c;
      if (t >= TASK_IDS) return;
      for (int k = 0; k < row_len_tbl[t]; k++) begin
        c = row_code_tbl[t][k];
        if (!seen[c]) begin
          seen[c] = 1'b1;
          run_list.push_back(c);
        end
      end
    endfunction

    // Returns 1 when the request changed the queue or started a run.
    function bit take_request(req_type_t req, task_id_t id);
      action_entry_t e;
      if (req == REQ_PUSH) begin
        if (id > TASK_ALL) return 0;
        if (id == TASK_ALL) begin
          queued[0] = TASK_ALL;
          depth_used = 1;
          return 1;
        end
        if (depth_used > 0 && queued[0] == TASK_ALL) return 0;
        for (int i = 0; i < depth_used; i++)
          if (queued[i] == id) return 0;
        if (depth_used + 1 >= QDEPTH) return 0;
        queued[depth_used] = id;
        depth_used++;
        return 1;
      end
      if (depth_used == 0) return 0;
      seen = '0;
      run_list.delete();
      if (depth_used == 1 && queued[0] == TASK_ALL) begin
        for (int t = 0; t < TASK_ALL; t++)
          if (row_len_tbl[t] != 0) walk_row(task_id_t'(t));
      end else begin
        for (int i = 0; i < depth_used; i++) walk_row(queued[i]);
      end
      depth_used = 0;
      seen = '0;
      foreach (run_list[i]) begin
        e.code = run_list[i];
        e.last = (i == run_list.size() - 1);
        pending_actions.push_back(e);
      end
      return 1;
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_action(action_t code, logic last);
      action_entry_t e;
      if (pending_actions.size() == 0) begin
        note_error($sformatf("unexpected action %0d last %0b", code, last));
        return;
      end
      e = pending_actions.pop_front();
      if (e.code !== code || e.last !== last)
        note_error($sformatf("action expected %0d last %0b, actual %0d last %0b",
                             e.code, e.last, code, last));
    endfunction

    function int unsigned pending();
      return pending_actions.size();
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  logic     in_req_type;
  task_id_t in_task_id;
  logic     out_valid;
  logic     out_ready;
  action_t  out_action_code;
  logic     out_last_action;

  ccq_action_model model;
  int unsigned     in_cnt = 0;
  int unsigned     out_cnt = 0;
  bit              burst = 0;

  coalescing_command_queue_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_task_id      (in_task_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_action_code (out_action_code),
    .out_last_action (out_last_action)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Transfer monitor: feeds the predictor and checks results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        void'(model.take_request(req_type_t'(in_req_type), in_task_id));
        in_cnt++;
      end
      if (out_valid && out_ready) begin
        model.check_action(out_action_code, out_last_action);
        out_cnt++;
      end
    end
  end

  // Offer one request at the falling edge and hold it until the transfer.
  task automatic offer(input req_type_t rt, input task_id_t id);
    int unsigned r;
    int unsigned gap;
    in_req_type = rt;
    in_task_id  = id;
    in_valid    = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    r = $urandom_range(0, 99);
    if (burst || r < 45) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Result side: random stalls, plus one long hold-off once traffic is flowing.
  initial begin
    int unsigned r;
    int unsigned n;
    bit held;
    held = 0;
    out_ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (!held && out_cnt >= 30) begin
        held = 1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_ready = 1'b1;
        n = $urandom_range(1, 8);
      end else if (r < 60) begin
        out_ready = 1'b1;
        n = $urandom_range(30, 80);
      end else if (r < 90) begin
        out_ready = 1'b0;
        n = $urandom_range(1, 3);
      end else if (r < 97) begin
        out_ready = 1'b0;
        n = $urandom_range(4, 12);
      end else begin
        out_ready = 1'b0;
        n = $urandom_range(20, 60);
      end
      repeat (n) @(negedge clk);
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("coalescing_command_queue_unit test failed");
    $finish;
  end

  initial begin
    int unsigned kind;
    int unsigned k;
    int unsigned j;
    task_id_t    tmp;
    task_id_t    perm[TASK_ALL];
    model       = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = REQ_PUSH;
    in_task_id  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // execute on an empty queue
    offer(REQ_EXEC, 5'd0);
    // out-of-range ids, a repeat, an empty row, then execute
    offer(REQ_PUSH, 5'd31);
    offer(REQ_PUSH, 5'd20);
    offer(REQ_PUSH, 5'd0);
    offer(REQ_PUSH, 5'd0);
    offer(REQ_PUSH, 5'd14);
    offer(REQ_PUSH, 5'd2);
    offer(REQ_EXEC, 5'd31);
    // only empty rows: no transfer but the queue drains
    offer(REQ_PUSH, 5'd2);
    offer(REQ_PUSH, 5'd3);
    offer(REQ_EXEC, 5'd0);
    // "all" blocks later pushes, then expands to every action
    offer(REQ_PUSH, TASK_ALL);
    offer(REQ_PUSH, 5'd5);
    offer(REQ_PUSH, TASK_ALL);
    offer(REQ_EXEC, 5'd0);
    // "all" replaces a queued task
    offer(REQ_PUSH, 5'd5);
    offer(REQ_PUSH, TASK_ALL);
    offer(REQ_EXEC, 5'd0);
    offer(REQ_PUSH, 5'd16);
    offer(REQ_PUSH, 5'd18);
    offer(REQ_EXEC, 5'd19);

    while (in_cnt < ITEM_GOAL) begin
      burst = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        k = $urandom_range(1, 6);
        repeat (k) offer(REQ_PUSH, task_id_t'($urandom_range(0, 18)));
        offer(REQ_EXEC, task_id_t'($urandom));
      end else if (kind < 70) begin
        // every plain task once, in random order, plus repeats
        for (int i = 0; i < TASK_ALL; i++) perm[i] = task_id_t'(i);
        for (int i = TASK_ALL - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        for (int i = 0; i < TASK_ALL; i++) offer(REQ_PUSH, perm[i]);
        repeat (2) offer(REQ_PUSH, task_id_t'($urandom_range(0, 18)));
        offer(REQ_EXEC, task_id_t'($urandom));
      end else if (kind < 82) begin
        k = $urandom_range(0, 4);
        repeat (k) offer(REQ_PUSH, task_id_t'($urandom_range(0, 18)));
        offer(REQ_PUSH, TASK_ALL);
        k = $urandom_range(0, 3);
        repeat (k) offer(REQ_PUSH, task_id_t'($urandom_range(0, 31)));
        offer(REQ_EXEC, task_id_t'($urandom));
      end else if (kind < 92) begin
        k = $urandom_range(1, 5);
        repeat (k) offer(req_type_t'($urandom_range(0, 1)),
                         task_id_t'($urandom_range(0, 31)));
      end else begin
        offer(REQ_EXEC, task_id_t'($urandom));
      end
    end
    in_valid = 1'b0;

    while (model.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (model.errors == 0 && model.pending() == 0) begin
      $display("coalescing_command_queue_unit test passed");
    end else begin
      $display("coalescing_command_queue_unit test failed");
    end
    $finish;
  end

endmodule
